// ----- rtl/core/pcf_pkg.sv -----
package pcf_pkg;

  localparam int PRICE_W   = 39;
  localparam int SUM_W     = 40;
  localparam int PAYLOAD_W = 64;
  localparam int LEN_W     = 4;
  localparam int OFFSET_W  = 3;
  localparam int STATUS_W  = 3;

  localparam logic [LEN_W-1:0] PAYLOAD_BYTES = 4'd8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNCHANGED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_READ_OK   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WRITE,
    ST_RDATA
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic exec_write;
    logic read_issue;
    logic load_empty;
    logic load_read;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic empty;
    logic slot_free;
  } dp_status_t;

  typedef struct packed {
    logic               direction;
    logic [PRICE_W-1:0] previous;
    logic [PRICE_W-1:0] current;
  } ring_entry_t;

endpackage

// ----- rtl/core/pcf_ctrl.sv -----
module pcf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcf_pkg::dp_status_t sts,
  output pcf_pkg::ctl_cmd_t   cmd
);

  pcf_pkg::ctl_state_t state_r;
  pcf_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pcf_pkg::ST_DISPATCH;
        end
      end
      pcf_pkg::ST_DISPATCH: begin
        if (sts.is_read) begin
          if (!sts.empty) begin
            state_nxt = pcf_pkg::ST_RDATA;
          end else if (sts.slot_free) begin
            state_nxt = pcf_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = pcf_pkg::ST_WRITE;
        end
      end
      pcf_pkg::ST_WRITE: begin
        if (sts.slot_free) begin
          state_nxt = pcf_pkg::ST_IDLE;
        end
      end
      pcf_pkg::ST_RDATA: begin
        if (sts.slot_free) begin
          state_nxt = pcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pcf_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pcf_pkg::ST_DISPATCH: begin
        if (sts.is_read) begin
          if (sts.empty) begin
            cmd.load_empty = sts.slot_free;
          end else begin
            cmd.read_issue = 1'b1;
          end
        end else begin
          cmd.decode = 1'b1;
        end
      end
      pcf_pkg::ST_WRITE: begin
        cmd.exec_write = sts.slot_free;
      end
      pcf_pkg::ST_RDATA: begin
        cmd.load_read = sts.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/pcf_datapath.sv -----
module pcf_datapath #(
  parameter int RING_DEPTH   = 16,
  parameter int DOLLAR_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pcf_pkg::OFFSET_W-1:0]        cfg_wr_data,
  input  logic                                in_cmd,
  input  logic [pcf_pkg::PAYLOAD_W-1:0]       in_payload,
  input  logic [pcf_pkg::LEN_W-1:0]           in_length,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pcf_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_direction,
  output logic [pcf_pkg::PRICE_W-1:0]         out_previous_price,
  output logic [pcf_pkg::PRICE_W-1:0]         out_current_price,
  input  pcf_pkg::ctl_cmd_t                   cmd,
  output pcf_pkg::dp_status_t                 sts
);

  localparam int PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DOLLAR_W = 8 * DOLLAR_BYTES;

  logic [pcf_pkg::OFFSET_W-1:0]  start_offset_r;
  logic                          cmd_r;
  logic [pcf_pkg::PAYLOAD_W-1:0] payload_r;
  logic [pcf_pkg::LEN_W-1:0]     length_r;
  logic [pcf_pkg::PRICE_W-1:0]   price_r;
  logic [pcf_pkg::PRICE_W-1:0]   price_nxt;
  logic [pcf_pkg::PRICE_W-1:0]   last_price_r;
  logic [PTR_W-1:0]              rptr_r;
  logic [PTR_W-1:0]              wptr_r;
  logic [PTR_W-1:0]              rptr_adv;
  logic [PTR_W-1:0]              wptr_adv;
  logic                          full;
  logic                          changed;
  logic                          do_queue;
  logic                          load_any;

  pcf_pkg::ring_entry_t ring_mem [RING_DEPTH];
  pcf_pkg::ring_entry_t rd_entry_r;
  pcf_pkg::ring_entry_t wr_entry;

  logic                          out_valid_r;
  logic [pcf_pkg::STATUS_W-1:0]  out_status_r;
  logic                          out_direction_r;
  logic [pcf_pkg::PRICE_W-1:0]   out_prev_r;
  logic [pcf_pkg::PRICE_W-1:0]   out_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= '0;
    end else if (cfg_wr_en) begin
      start_offset_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      payload_r <= in_payload;
      length_r  <= in_length;
    end
  end

  // price decode: cents byte at start_offset, little-endian dollar bytes after it
  always_comb begin
    logic [pcf_pkg::LEN_W-1:0] len_eff;
    logic [pcf_pkg::LEN_W-1:0] idx;
    logic [DOLLAR_W-1:0]       dollars;
    logic [7:0]                cents;
    logic [pcf_pkg::SUM_W-1:0] d_ext;
    logic [pcf_pkg::SUM_W-1:0] sum;
    len_eff = (length_r > pcf_pkg::PAYLOAD_BYTES) ? pcf_pkg::PAYLOAD_BYTES : length_r;
    cents   = payload_r[{start_offset_r, 3'b000} +: 8];
    dollars = '0;
    for (int k = 0; k < DOLLAR_BYTES; k++) begin
      idx = pcf_pkg::LEN_W'(start_offset_r) + pcf_pkg::LEN_W'(k + 1);
      if ((idx < len_eff) && !idx[pcf_pkg::LEN_W-1]) begin
        dollars[8*k +: 8] = payload_r[{idx[2:0], 3'b000} +: 8];
      end
    end
    d_ext = pcf_pkg::SUM_W'(dollars);
    // x100 = x64 + x32 + x4
    sum = (d_ext << 6) + (d_ext << 5) + (d_ext << 2) + pcf_pkg::SUM_W'(cents);
    price_nxt = sum[pcf_pkg::PRICE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      price_r <= price_nxt;
    end
  end

  assign rptr_adv = (rptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
  assign wptr_adv = (wptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
  assign full     = (wptr_adv == rptr_r);
  assign changed  = (price_r != last_price_r);
  assign do_queue = cmd.exec_write && !full && changed;

  assign wr_entry.direction = (price_r < last_price_r);
  assign wr_entry.previous  = last_price_r;
  assign wr_entry.current   = price_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rptr_r       <= '0;
      wptr_r       <= '0;
      last_price_r <= '0;
    end else begin
      if (do_queue) begin
        wptr_r       <= wptr_adv;
        last_price_r <= price_r;
      end
      if (cmd.read_issue) begin
        rptr_r <= rptr_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_queue) begin
      ring_mem[wptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_entry_r <= ring_mem[rptr_r];
    end
  end

  assign load_any = cmd.exec_write || cmd.load_empty || cmd.load_read;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_any) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      out_status_r    <= pcf_pkg::STATUS_READ_OK;
      out_direction_r <= rd_entry_r.direction;
      out_prev_r      <= rd_entry_r.previous;
      out_cur_r       <= rd_entry_r.current;
    end else if (cmd.load_empty || cmd.exec_write) begin
      out_direction_r <= 1'b0;
      out_prev_r      <= '0;
      out_cur_r       <= '0;
      if (cmd.load_empty) begin
        out_status_r <= pcf_pkg::STATUS_EMPTY;
      end else if (full) begin
        out_status_r <= pcf_pkg::STATUS_OVERFLOW;
      end else if (!changed) begin
        out_status_r <= pcf_pkg::STATUS_UNCHANGED;
      end else begin
        out_status_r <= pcf_pkg::STATUS_QUEUED;
      end
    end
  end

  assign sts.is_read   = (cmd_r == pcf_pkg::CMD_READ);
  assign sts.empty     = (rptr_r == wptr_r);
  assign sts.slot_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_direction      = out_direction_r;
  assign out_previous_price = out_prev_r;
  assign out_current_price  = out_cur_r;

endmodule

// ----- rtl/core/price_change_filter_fifo_unit.sv -----
// Steps: a write passes capture, decode and output load; a read passes capture, ring
// read and output load (capture and output load for a read of an empty ring).
// out_valid rises when the output register is loaded; a load waits while a stalled
// result still holds that register. The controller holds one item at a time through
// capture, decode/ring access and output load; no new item is taken before that load.
// Reset (rst_n, synchronous): pointers, last price, start offset and out_valid
// clear; ring contents are not cleared.
module price_change_filter_fifo_unit #(
  parameter int RING_DEPTH   = 16,
  parameter int DOLLAR_BYTES = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pcf_pkg::OFFSET_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [pcf_pkg::PAYLOAD_W-1:0] in_payload,
  input  logic [pcf_pkg::LEN_W-1:0]     in_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pcf_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_direction,
  output logic [pcf_pkg::PRICE_W-1:0]   out_previous_price,
  output logic [pcf_pkg::PRICE_W-1:0]   out_current_price
);

  pcf_pkg::ctl_cmd_t   ctl_cmd;
  pcf_pkg::dp_status_t dp_sts;

  pcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  pcf_datapath #(
    .RING_DEPTH   (RING_DEPTH),
    .DOLLAR_BYTES (DOLLAR_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_cmd             (in_cmd),
    .in_payload         (in_payload),
    .in_length          (in_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_direction      (out_direction),
    .out_previous_price (out_previous_price),
    .out_current_price  (out_current_price),
    .cmd                (ctl_cmd),
    .sts                (dp_sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while an item is in work");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_cmd.exec_write || ctl_cmd.load_empty || ctl_cmd.load_read) |->
      ($onehot({ctl_cmd.exec_write, ctl_cmd.load_empty, ctl_cmd.load_read})
       && dp_sts.slot_free))
    else $error("output register loaded while occupied or twice");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.read_issue |-> !dp_sts.empty)
    else $error("ring read issued while empty");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != pcf_pkg::STATUS_READ_OK)) |->
      (!out_direction && (out_previous_price == '0) && (out_current_price == '0)))
    else $error("non-read result carries entry fields");

endmodule

// ----- verif/tb_price_change_filter_fifo_unit.sv -----
`timescale 1ns / 100ps

class price_change_scoreboard;

  typedef struct packed {
    logic [pcf_pkg::STATUS_W-1:0] status;
    logic                         direction;
    logic [pcf_pkg::PRICE_W-1:0]  previous_price;
    logic [pcf_pkg::PRICE_W-1:0]  current_price;
  } quote_t;

  quote_t                      expected_q[$];
  logic [pcf_pkg::PRICE_W-1:0] ring_prev[256];
  logic [pcf_pkg::PRICE_W-1:0] ring_cur[256];
  logic                        ring_dir[256];
  int                          depth;
  int                          rd_ptr;
  int                          wr_ptr;
  logic [pcf_pkg::PRICE_W-1:0] last_price;
  logic [pcf_pkg::OFFSET_W-1:0] start_offset;
  int                          errors;
  int                          writes;
  int                          reads;
  int                          status_seen[5];

  function new(int ring_depth);
    depth = ring_depth;
    rd_ptr = 0;
    wr_ptr = 0;
    last_price = '0;
    start_offset = '0;
    errors = 0;
    writes = 0;
    reads = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  // cents byte at start_offset, then up to 4 little-endian dollar bytes below length
  function logic [pcf_pkg::PRICE_W-1:0] price_in_hundredths(logic [63:0] payload,
                                                            logic [3:0] len);
    int   first;
    int   idx;
    int   n;
    logic [31:0] dollars;
    logic [63:0] sum;
    first = int'(start_offset);
    n = (len > 4'd8) ? 8 : int'(len);
    dollars = '0;
    for (int k = 0; k < 4; k++) begin
      idx = first + 1 + k;
      if (idx < n && idx < 8) dollars[8*k +: 8] = payload[8*idx +: 8];
    end
    sum = 64'(dollars) * 64'd100 + 64'(payload[8*first +: 8]);
    return sum[pcf_pkg::PRICE_W-1:0];
  endfunction

  function void note_item(logic cmd, logic [63:0] payload, logic [3:0] len);
    quote_t q;
    logic [pcf_pkg::PRICE_W-1:0] price;
    int nxt;
    q = '0;
    if (cmd == pcf_pkg::CMD_READ) begin
      reads++;
      if (rd_ptr == wr_ptr) begin
        q.status = pcf_pkg::STATUS_EMPTY;
      end else begin
        q.status = pcf_pkg::STATUS_READ_OK;
        q.direction = ring_dir[rd_ptr];
        q.previous_price = ring_prev[rd_ptr];
        q.current_price = ring_cur[rd_ptr];
        rd_ptr = (rd_ptr + 1) % depth;
      end
    end else begin
      writes++;
      nxt = (wr_ptr + 1) % depth;
      if (nxt == rd_ptr) begin
        q.status = pcf_pkg::STATUS_OVERFLOW;
      end else begin
        price = price_in_hundredths(payload, len);
        if (price == last_price) begin
          q.status = pcf_pkg::STATUS_UNCHANGED;
        end else begin
          ring_dir[wr_ptr] = (price < last_price);
          ring_prev[wr_ptr] = last_price;
          ring_cur[wr_ptr] = price;
          last_price = price;
          wr_ptr = nxt;
          q.status = pcf_pkg::STATUS_QUEUED;
        end
      end
    end
    expected_q.push_back(q);
  endfunction

  function void check_result(logic [pcf_pkg::STATUS_W-1:0] status, logic direction,
                             logic [pcf_pkg::PRICE_W-1:0] previous_price,
                             logic [pcf_pkg::PRICE_W-1:0] current_price);
    quote_t q;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: status %0d dir %0d prev %0d cur %0d", $time,
               status, direction, previous_price, current_price);
      errors++;
      return;
    end
    q = expected_q.pop_front();
    if (status < 3'd5) status_seen[status]++;
    if (status !== q.status) begin
      $display("%0t: status mismatch: expected %0d, actual %0d", $time, q.status, status);
      errors++;
    end
    if (direction !== q.direction) begin
      $display("%0t: direction mismatch: expected %0d, actual %0d", $time, q.direction,
               direction);
      errors++;
    end
    if (previous_price !== q.previous_price) begin
      $display("%0t: previous_price mismatch: expected %0d, actual %0d", $time,
               q.previous_price, previous_price);
      errors++;
    end
    if (current_price !== q.current_price) begin
      $display("%0t: current_price mismatch: expected %0d, actual %0d", $time,
               q.current_price, current_price);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

endclass

module tb_price_change_filter_fifo_unit;

  localparam int RING_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [pcf_pkg::OFFSET_W-1:0]  cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_cmd;
  logic [pcf_pkg::PAYLOAD_W-1:0] in_payload;
  logic [pcf_pkg::LEN_W-1:0]     in_length;
  logic                          out_valid;
  logic                          out_stall;
  logic [pcf_pkg::STATUS_W-1:0]  out_status;
  logic                          out_direction;
  logic [pcf_pkg::PRICE_W-1:0]   out_previous_price;
  logic [pcf_pkg::PRICE_W-1:0]   out_current_price;

  price_change_scoreboard sb;

  bit          quiet;
  bit          hold_req;
  bit          hold_done;
  int          hold_left;
  int          cycle_count;
  int          offsets_used;
  int          cur_offset;
  logic [63:0] last_payload;
  logic [3:0]  last_len;

  price_change_filter_fifo_unit #(
    .RING_DEPTH  (RING_DEPTH),
    .DOLLAR_BYTES(4)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_payload        (in_payload),
    .in_length         (in_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_direction     (out_direction),
    .out_previous_price(out_previous_price),
    .out_current_price (out_current_price)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
             sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check accepted results, random stalls, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_status, out_direction, out_previous_price, out_current_price);
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1'b1;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_left = 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [63:0] payload,
                           input logic [3:0] len);
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_payload <= payload;
    in_length  <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(cmd, payload, len);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // every item yields a result, so an empty queue means the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[pcf_pkg::OFFSET_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.start_offset = value[pcf_pkg::OFFSET_W-1:0];
    cur_offset = value;
    offsets_used++;
  endtask

  task automatic random_item(input int write_pct);
    logic [63:0] payload;
    logic [3:0]  len;
    int          pick;
    payload = {$urandom, $urandom};
    len = $urandom_range(0, 15);
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 99) >= write_pct) begin
      send_item(pcf_pkg::CMD_READ, payload, len);
    end else begin
      if (pick < 3) begin
        // same price again
        payload = last_payload;
        len = last_len;
      end else if (pick < 5) begin
        // few dollar bytes: small prices, both directions
        len = 4'(cur_offset + $urandom_range(0, 2));
      end
      last_payload = payload;
      last_len = len;
      send_item(pcf_pkg::CMD_WRITE, payload, len);
    end
  endtask

  initial begin
    int write_pct;
    int off;
    sb = new(RING_DEPTH);
    quiet = 1'b0;
    hold_req = 1'b0;
    offsets_used = 0;
    cur_offset = 0;
    last_payload = '0;
    last_len = '0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    in_cmd      <= pcf_pkg::CMD_WRITE;
    in_payload  <= '0;
    in_length   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset offset
    send_item(pcf_pkg::CMD_READ, 64'h0, 4'd0);
    send_item(pcf_pkg::CMD_WRITE, 64'h0, 4'd0);
    send_item(pcf_pkg::CMD_WRITE, 64'h0000_00FF_FFFF_FF63, 4'd5);
    send_item(pcf_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    send_item(pcf_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(pcf_pkg::CMD_WRITE, 64'hFFFF_FFFF_FFFF_FF05, 4'd1);
    send_item(pcf_pkg::CMD_WRITE, 64'h1234_5678_9ABC_DE20, 4'd0);
    send_item(pcf_pkg::CMD_WRITE, 64'hAAAA_AAAA_AA01_0200, 4'd3);
    repeat (5) send_item(pcf_pkg::CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    drain();

    // cents byte in the top position, no dollar bytes fit
    write_offset(7);
    send_item(pcf_pkg::CMD_WRITE, 64'h42FF_FFFF_FFFF_FFFF, 4'd8);
    send_item(pcf_pkg::CMD_WRITE, 64'h00FF_FFFF_FFFF_FFFF, 4'd15);
    repeat (3) send_item(pcf_pkg::CMD_READ, 64'h0, 4'd0);

    for (int p = 0; p < 6; p++) begin
      drain();
      off = (p == 0) ? 0 : (p == 5) ? 7 : $urandom_range(0, 7);
      write_offset(off);
      quiet = (p == 3);
      for (int b = 0; b < 5; b++) begin
        case ($urandom_range(0, 2))
          0: write_pct = 15;
          1: write_pct = 50;
          default: write_pct = 85;
        endcase
        for (int i = 0; i < 50; i++) begin
          if (p == 2 && b == 1 && i == 0) hold_req = 1'b1;
          random_item(write_pct);
        end
      end
    end
    quiet = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d writes and %0d reads across %0d start offset settings.",
             sb.writes, sb.reads, offsets_used);
    $display("Results: queued %0d, unchanged %0d, overflow %0d, empty %0d, read %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
